// ===== rtl/core/spfp_pkg.sv =====
// Shared constants and types for the signed position frame parser.
package spfp_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChB      = 8'h42;
  localparam logic [7:0] ChL      = 8'h4C;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam int unsigned MagW     = 19;
  localparam int unsigned PosW     = 16;
  localparam int unsigned SeqW     = 8;
  localparam int unsigned OutDataW = PosW + SeqW;

  localparam logic [MagW-1:0] AccLimit = 19'd32768;
  localparam logic [MagW-1:0] MmLimit  = 19'd3276;

  typedef enum logic [5:0] {
    PhIdle   = 6'b000001,
    PhDollar = 6'b000010,
    PhGotB   = 6'b000100,
    PhSign   = 6'b001000,
    PhDigits = 6'b010000,
    PhGotL   = 6'b100000
  } phase_e;

endpackage

// ===== rtl/core/signed_position_frame_parser_core.sv =====
// Top level: byte stream parser for position and lost frames.
//
//  channel  | dir | tdata (low bit first)                        | tuser
//  s_axis   | in  | [7:0] byte_value                             | -
//  m_axis   | out | [15:0] position_tenth_mm, [23:16] sequence_res | target_valid
//
// An accepted byte lands in an input register and is parsed from there; a
// frame end writes the result register, which drives m_axis.
// One byte per cycle is sustained while the result register drains.
// rst_ni clears the phase, accumulator, frame count and both valid flags.
// A held result stalls parsing of the byte behind it; input stays open while
// the input register is empty.
module signed_position_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] byte_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spfp_pkg::OutDataW-1:0] m_axis_tdata,  // [15:0] position, [23:16] sequence
  output logic                          m_axis_tuser   // [0] target_valid
);
  import spfp_pkg::*;

  logic            in_valid_q;
  logic [7:0]      byte_q;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic            seen_q, seen_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [SeqW-1:0] count_q, count_d;

  logic            out_valid_q;
  logic [PosW-1:0] pos_q;
  logic [SeqW-1:0] seq_q;
  logic            tv_q;

  logic            advance;
  logic            emit;
  logic [PosW-1:0] emit_pos;
  logic            emit_tv;
  logic            is_digit;
  logic [3:0]      digit;
  logic [MagW-1:0] mag_mac;
  logic [MagW-1:0] mag_clamp;
  logic [PosW-1:0] pos_abs;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  assign is_digit = byte_q inside {[ChZero:ChNine]};
  assign digit    = 4'(byte_q - ChZero);
  // magnitude*10 + digit; only used while magnitude < 32768 so 15 bits suffice
  assign mag_mac  = (MagW'(mag_q[14:0]) << 3) + (MagW'(mag_q[14:0]) << 1) + MagW'(digit);
  assign mag_clamp = (mag_q > MmLimit) ? MmLimit : mag_q;
  assign pos_abs   = (PosW'(mag_clamp) << 3) + (PosW'(mag_clamp) << 1);

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    mag_d    = mag_q;
    emit     = 1'b0;
    emit_pos = '0;
    emit_tv  = 1'b0;
    case (phase_q)
      PhIdle: begin
        if (byte_q == ChDollar) phase_d = PhDollar;
      end
      PhDollar: begin
        if (byte_q == ChB)      phase_d = PhGotB;
        else if (byte_q == ChL) phase_d = PhGotL;
        else                    phase_d = PhIdle;
      end
      PhGotB: begin
        if (byte_q == ChComma) begin
          phase_d = PhSign;
          neg_d   = 1'b0;
          mag_d   = '0;
          seen_d  = 1'b0;
        end else begin
          phase_d = PhIdle;
        end
      end
      PhSign: begin
        if (byte_q == ChMinus) begin
          neg_d   = 1'b1;
          phase_d = PhDigits;
        end else if (byte_q == ChPlus) begin
          phase_d = PhDigits;
        end else if (is_digit) begin
          mag_d   = MagW'(digit);
          seen_d  = 1'b1;
          phase_d = PhDigits;
        end else begin
          phase_d = PhIdle;
        end
      end
      PhDigits: begin
        if (is_digit) begin
          if (mag_q < AccLimit) mag_d = mag_mac;
          seen_d = 1'b1;
        end else if (byte_q == ChHash && seen_q) begin
          emit     = 1'b1;
          emit_tv  = 1'b1;
          emit_pos = neg_q ? (PosW'(0) - pos_abs) : pos_abs;
          phase_d  = PhIdle;
        end else begin
          phase_d = (byte_q == ChDollar) ? PhDollar : PhIdle;
        end
      end
      PhGotL: begin
        if (byte_q == ChHash) begin
          emit    = 1'b1;
          phase_d = PhIdle;
        end else begin
          phase_d = (byte_q == ChDollar) ? PhDollar : PhIdle;
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  assign count_d = count_q + SeqW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PhIdle;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      mag_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (in_valid_q && advance) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        mag_q   <= mag_d;
        if (emit) count_q <= count_d;
      end
      if (advance) out_valid_q <= in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) byte_q <= s_axis_tdata;
    if (advance && in_valid_q && emit) begin
      pos_q <= emit_pos;
      seq_q <= count_d;
      tv_q  <= emit_tv;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {seq_q, pos_q};
  assign m_axis_tuser  = tv_q;

endmodule
